// ===== sv/cdq_pkg.sv =====
// Shared constants and types for the circular deque.
`default_nettype none
package cdq_pkg;

   localparam int DEPTH       = 8;
   localparam int DATA_WIDTH  = 32;
   localparam int FIELD_WIDTH = 32;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);
   localparam int STATUS_WIDTH = 2;
   localparam int KIND_WIDTH  = 2;

   localparam logic [KIND_WIDTH-1:0] KIND_INS_FRONT = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_INS_REAR  = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_REM_FRONT = 2'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_REM_REAR  = 2'd3;

   localparam logic [STATUS_WIDTH-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_PUSH_FRONT,
      OP_PUSH_REAR,
      OP_POP_FRONT,
      OP_POP_REAR
   } op_type;

   // Broadcast to every cell in the row each cycle.
   typedef struct packed {
      op_type                op;
      logic [DATA_WIDTH-1:0] ins_data;
   } ctl_type;

endpackage
`default_nettype wire

// ===== sv/cdq_req_if.sv =====
// Request channel: operation kind and element to insert.
`default_nettype none
interface cdq_req_if;
   logic                                valid;
   logic                                ready;
   logic [cdq_pkg::KIND_WIDTH-1:0]      kind;
   logic signed [cdq_pkg::FIELD_WIDTH-1:0] data_in;

   modport source (output valid, output kind, output data_in, input ready);
   modport sink   (input valid, input kind, input data_in, output ready);
endinterface
`default_nettype wire

// ===== sv/cdq_rsp_if.sv =====
// Response channel: removed element, status and occupancy.
`default_nettype none
interface cdq_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [cdq_pkg::FIELD_WIDTH-1:0] data_out;
   logic [cdq_pkg::STATUS_WIDTH-1:0]       status;
   logic [cdq_pkg::COUNT_WIDTH-1:0]        occupancy;

   modport source (output valid, output data_out, output status, output occupancy,
                   input ready);
   modport sink   (input valid, input data_out, input status, input occupancy,
                   output ready);
endinterface
`default_nettype wire

// ===== sv/cdq_cell.sv =====
// One deque slot: holds an element and shifts with its neighbors.
`default_nettype none
module cdq_cell (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire cdq_pkg::ctl_type                   ctl,
   input  wire logic                               left_valid,
   input  wire logic [cdq_pkg::DATA_WIDTH-1:0]     left_data,
   input  wire logic                               right_valid,
   input  wire logic [cdq_pkg::DATA_WIDTH-1:0]     right_data,
   output logic                                    valid,
   output logic [cdq_pkg::DATA_WIDTH-1:0]          data,
   output logic                                    is_last
);

   logic                              valid_ff, valid_in;
   logic [cdq_pkg::DATA_WIDTH-1:0]    data_ff, data_in;

   assign valid   = valid_ff;
   assign data    = data_ff;
   assign is_last = valid_ff & ~right_valid;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      unique case (ctl.op)
         cdq_pkg::OP_HOLD: begin
         end
         cdq_pkg::OP_PUSH_FRONT: begin
            valid_in = left_valid;
            data_in  = left_data;
         end
         cdq_pkg::OP_PUSH_REAR: begin
            // first empty slot takes the new item
            if (!valid_ff && left_valid) begin
               valid_in = 1'b1;
               data_in  = ctl.ins_data;
            end
         end
         cdq_pkg::OP_POP_FRONT: begin
            valid_in = right_valid;
            data_in  = right_data;
         end
         cdq_pkg::OP_POP_REAR: begin
            if (is_last) begin
               valid_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

endmodule
`default_nettype wire

// ===== sv/circular_deque.sv =====
// Circular deque top level: a row of shifting slots with the front at slot 0.
// The response is valid in the cycle after the request is accepted.
// Throughput: one item per cycle while the response side is ready; the slot row updates in the accept cycle and
// the response register frees up in the same cycle it is taken.
// Reset (synchronous, active high) empties the deque and drops any pending
// response; element data is not cleared.
`default_nettype none
module circular_deque (
   input  wire logic    clock,
   input  wire logic    reset,
   cdq_req_if.sink      req_ch,
   cdq_rsp_if.source    rsp_ch
);

   localparam int N = cdq_pkg::DEPTH;
   localparam int W = cdq_pkg::DATA_WIDTH;

   // slot row
   logic [N-1:0]         cell_valid;
   logic [N-1:0]         cell_last;
   logic [W-1:0]         cell_data [N];
   cdq_pkg::ctl_type     ctl;

   // occupancy and response register
   logic [cdq_pkg::COUNT_WIDTH-1:0]  count_ff, count_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [cdq_pkg::FIELD_WIDTH-1:0]  data_out_ff, data_out_in;
   logic [cdq_pkg::STATUS_WIDTH-1:0] status_ff, status_in;
   logic [cdq_pkg::COUNT_WIDTH-1:0]  occ_ff, occ_in;

   logic          accept;
   logic          is_insert;
   logic          full;
   logic          empty;
   logic [W-1:0]  rear_data;
   logic [W-1:0]  pick_data;

   // a new item goes in whenever the response slot is empty or draining
   assign req_ch.ready = ~rsp_valid_ff | rsp_ch.ready;
   assign accept       = req_ch.valid & req_ch.ready;

   assign is_insert = (req_ch.kind == cdq_pkg::KIND_INS_FRONT) ||
                      (req_ch.kind == cdq_pkg::KIND_INS_REAR);
   assign full  = (count_ff == cdq_pkg::COUNT_WIDTH'(N));
   assign empty = (count_ff == '0);

   // rear element is the one valid slot whose right neighbor is empty
   always_comb begin
      rear_data = '0;
      for (int i = 0; i < N; i++) begin
         rear_data = rear_data | (cell_data[i] & {W{cell_last[i]}});
      end
   end

   assign pick_data = (req_ch.kind == cdq_pkg::KIND_REM_FRONT) ? cell_data[0] : rear_data;

   always_comb begin
      ctl.op       = cdq_pkg::OP_HOLD;
      ctl.ins_data = req_ch.data_in[W-1:0];
      count_in     = count_ff;
      status_in    = cdq_pkg::STATUS_DONE;
      data_out_in  = '0;
      if (accept) begin
         if (is_insert) begin
            if (full) begin
               status_in = cdq_pkg::STATUS_FULL;
            end else begin
               // insert into empty lands in slot 0 for either end
               ctl.op   = (req_ch.kind == cdq_pkg::KIND_INS_FRONT) ?
                          cdq_pkg::OP_PUSH_FRONT : cdq_pkg::OP_PUSH_REAR;
               count_in = count_ff + 1'b1;
            end
         end else begin
            if (empty) begin
               status_in = cdq_pkg::STATUS_EMPTY;
            end else begin
               ctl.op      = (req_ch.kind == cdq_pkg::KIND_REM_FRONT) ?
                             cdq_pkg::OP_POP_FRONT : cdq_pkg::OP_POP_REAR;
               count_in    = count_ff - 1'b1;
               data_out_in = cdq_pkg::FIELD_WIDTH'(signed'(pick_data));
            end
         end
      end
      occ_in = count_in;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_cell
         logic          lv, rv;
         logic [W-1:0]  ld, rd;
         if (g == 0) begin : g_head
            // slot 0 sees the incoming element as its left neighbor
            assign lv = 1'b1;
            assign ld = ctl.ins_data;
         end else begin : g_mid
            assign lv = cell_valid[g-1];
            assign ld = cell_data[g-1];
         end
         if (g == N - 1) begin : g_tail
            assign rv = 1'b0;
            assign rd = '0;
         end else begin : g_body
            assign rv = cell_valid[g+1];
            assign rd = cell_data[g+1];
         end
         cdq_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl         (ctl),
            .left_valid  (lv),
            .left_data   (ld),
            .right_valid (rv),
            .right_data  (rd),
            .valid       (cell_valid[g]),
            .data        (cell_data[g]),
            .is_last     (cell_last[g])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         data_out_ff <= data_out_in;
         status_ff   <= status_in;
         occ_ff      <= occ_in;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.data_out  = data_out_ff;
   assign rsp_ch.status    = status_ff;
   assign rsp_ch.occupancy = occ_ff;

endmodule
`default_nettype wire
